### sv/bopc_pkg.sv
// Package for the binned overlap placement check.
// Holds widths, register indexes, status codes, FSM state and ctrl/datapath structs.
// No dependencies.
`default_nettype none

package bopc_pkg;

  localparam int COORD_W     = 24;
  localparam int DBL_W       = COORD_W + 1;
  localparam int SQ_W        = 2 * DBL_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int MAX_DIMS    = 3;
  localparam int BIN_W       = 3;
  localparam int STORE_DEPTH = 1024;
  localparam int TOTAL_W     = 11;
  localparam int CURVED_W    = 2;
  localparam int STATUS_W    = 2;
  localparam int APB_AW      = 4;
  localparam int APB_DW      = 32;

  localparam logic [COORD_W-1:0] BOX_RESET = COORD_W'(1048576);

  typedef enum logic [1:0] {
    REG_BOX_X,
    REG_BOX_Y,
    REG_BOX_Z,
    REG_CURVED
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PLACED,
    ST_WALL,
    ST_OVERLAP,
    ST_FULL
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_WALL,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0]  box_x;
    logic [COORD_W-1:0]  box_y;
    logic [COORD_W-1:0]  box_z;
    logic [CURVED_W-1:0] curved;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic wall_go;
    logic rd_go;
    logic mode_wall;
    logic flush;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic wall_needed;
    logic fill_zero;
    logic rd_done;
    logic pipe_empty;
    logic hit;
    logic wall_fail;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

### sv/bopc_cfg.sv
// APB register file: box sides and number of curved dimensions.
// Depends on bopc_pkg.
`default_nettype none

module bopc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bopc_pkg::APB_AW-1:0]   paddr,
  input  logic [bopc_pkg::APB_DW-1:0]   pwdata,
  output logic [bopc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output bopc_pkg::cfg_t                cfg
);
  import bopc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_BOX_X:  cfg_nxt.box_x  = pwdata[COORD_W-1:0];
        REG_BOX_Y:  cfg_nxt.box_y  = pwdata[COORD_W-1:0];
        REG_BOX_Z:  cfg_nxt.box_z  = pwdata[COORD_W-1:0];
        REG_CURVED: cfg_nxt.curved = pwdata[CURVED_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BOX_X:  prdata = APB_DW'(cfg_r.box_x);
      REG_BOX_Y:  prdata = APB_DW'(cfg_r.box_y);
      REG_BOX_Z:  prdata = APB_DW'(cfg_r.box_z);
      REG_CURVED: prdata = APB_DW'(cfg_r.curved);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{box_x: BOX_RESET, box_y: BOX_RESET, box_z: BOX_RESET, curved: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/bopc_ctrl.sv
// Controller FSM: load, curved wall test, bin scan, commit of one item.
// Depends on bopc_pkg; drives bopc_dp through ctrl_cmd_t.
`default_nettype none

module bopc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bopc_pkg::dp_stat_t   stat,
  output bopc_pkg::ctrl_cmd_t  cmd
);
  import bopc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PREP;
      end
      S_PREP: begin
        if (stat.wall_needed) state_nxt = S_WALL;
        else if (stat.fill_zero) state_nxt = S_FINISH;
        else state_nxt = S_SCAN;
      end
      S_WALL: begin
        if (stat.pipe_empty) begin
          if (stat.wall_fail || stat.fill_zero) state_nxt = S_FINISH;
          else state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.hit || (stat.rd_done && stat.pipe_empty)) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == S_IDLE);
    cmd           = '0;
    cmd.load      = (state_r == S_IDLE) && in_valid;
    cmd.wall_go   = (state_r == S_PREP) && stat.wall_needed;
    cmd.mode_wall = (state_r == S_WALL);
    cmd.rd_go     = (state_r == S_SCAN) && !stat.rd_done && !stat.hit;
    cmd.flush     = (state_r == S_FINISH);
    cmd.commit    = (state_r == S_FINISH) && !stat.out_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/bopc_dp.sv
// Datapath: candidate registers, per-bin sphere memory, fill counters,
// three-stage distance pipeline and result register. Depends on bopc_pkg.
`default_nettype none

module bopc_dp #(
  parameter int NUM_DIMS     = 3,
  parameter int BIN_CAPACITY = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bopc_pkg::cfg_t                    cfg,
  input  bopc_pkg::ctrl_cmd_t               cmd,
  output bopc_pkg::dp_stat_t                stat,
  input  logic [bopc_pkg::COORD_W-1:0]      in_pos_x,
  input  logic [bopc_pkg::COORD_W-1:0]      in_pos_y,
  input  logic [bopc_pkg::COORD_W-1:0]      in_pos_z,
  input  logic [bopc_pkg::COORD_W-1:0]      in_diameter,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_accepted,
  output logic [bopc_pkg::STATUS_W-1:0]     out_status,
  output logic [bopc_pkg::BIN_W-1:0]        out_bin_index,
  output logic [bopc_pkg::TOTAL_W-1:0]      out_placed_count
);
  import bopc_pkg::*;

  localparam int NUM_BINS  = 1 << NUM_DIMS;
  localparam int CAP_EFF   = (BIN_CAPACITY < STORE_DEPTH) ? BIN_CAPACITY : STORE_DEPTH;
  localparam int SLOT_W    = (CAP_EFF > 1) ? $clog2(CAP_EFF) : 1;
  localparam int FILL_W    = $clog2(CAP_EFF + 1);
  localparam int ADDR_W    = NUM_DIMS + SLOT_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int ENTRY_W   = (NUM_DIMS + 1) * COORD_W;

  logic [COORD_W-1:0]  in_pos [MAX_DIMS];
  logic [COORD_W-1:0]  box    [MAX_DIMS];
  logic [CURVED_W-1:0] kc;

  logic [COORD_W-1:0]  pos_r [NUM_DIMS];
  logic [COORD_W-1:0]  dia_r;
  logic [NUM_DIMS-1:0] bin_r;
  logic [NUM_DIMS-1:0] bin_nxt;
  logic [FILL_W-1:0]   fill_r [NUM_BINS];
  logic [FILL_W-1:0]   fill_cur;
  logic [TOTAL_W-1:0]  total_r;
  logic [FILL_W-1:0]   k_r;

  logic [ENTRY_W-1:0]  mem [MEM_DEPTH];
  logic [ENTRY_W-1:0]  mem_q_r;
  logic [ENTRY_W-1:0]  entry;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;

  logic                v_mem_r;
  logic                v_diff_r;
  logic                v_sq_r;
  logic [DBL_W-1:0]    lane_a   [NUM_DIMS];
  logic [DBL_W-1:0]    lane_b   [NUM_DIMS];
  logic [DBL_W-1:0]    diff_nxt [NUM_DIMS];
  logic [DBL_W-1:0]    diff_r   [NUM_DIMS];
  logic [DBL_W-1:0]    rs_nxt;
  logic [DBL_W-1:0]    rs_r;
  logic [SQ_W-1:0]     sq_r     [NUM_DIMS];
  logic [SQ_W-1:0]     rr_r;
  logic [SUM_W-1:0]    sum;
  logic                le;

  logic                hit_r;
  logic                wall_fail_r;
  logic                bin_full;
  status_t             res_status;
  logic                placed;

  logic                out_valid_r;
  logic                out_accepted_r;
  status_t             out_status_r;
  logic [NUM_DIMS-1:0] out_bin_r;
  logic [TOTAL_W-1:0]  out_count_r;

  assign in_pos[0] = in_pos_x;
  assign in_pos[1] = in_pos_y;
  assign in_pos[2] = in_pos_z;
  assign box[0]    = cfg.box_x;
  assign box[1]    = cfg.box_y;
  assign box[2]    = cfg.box_z;
  assign kc        = (int'(cfg.curved) > NUM_DIMS) ? CURVED_W'(NUM_DIMS) : cfg.curved;
  assign fill_cur  = fill_r[bin_r];

  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      bin_nxt[d] = {in_pos[d], 1'b0} > {1'b0, box[d]};
    end
  end

  always_comb begin
    entry = '0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      entry[d*COORD_W +: COORD_W] = pos_r[d];
    end
    entry[NUM_DIMS*COORD_W +: COORD_W] = dia_r;
  end

  assign wr_addr = {bin_r, fill_cur[SLOT_W-1:0]};
  assign rd_addr = {bin_r, k_r[SLOT_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.commit && placed) begin
      mem[wr_addr] <= entry;
    end
    if (cmd.rd_go) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // stage A: coordinate differences (doubled scale) and diameter sum / radius
  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      if (cmd.mode_wall) begin
        lane_a[d] = {pos_r[d], 1'b0};
        lane_b[d] = (d < int'(kc)) ? {1'b0, cfg.box_x} : {pos_r[d], 1'b0};
      end else begin
        lane_a[d] = {mem_q_r[d*COORD_W +: COORD_W], 1'b0};
        lane_b[d] = {pos_r[d], 1'b0};
      end
      diff_nxt[d] = (lane_a[d] > lane_b[d]) ? lane_a[d] - lane_b[d] : lane_b[d] - lane_a[d];
    end
    if (cmd.mode_wall) begin
      rs_nxt = {1'b0, cfg.box_x};
    end else begin
      rs_nxt = {1'b0, mem_q_r[NUM_DIMS*COORD_W +: COORD_W]} + {1'b0, dia_r};
    end
  end

  // stage C: sum of squares against squared reach
  always_comb begin
    sum = '0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      sum = sum + SUM_W'(sq_r[d]);
    end
    le = (sum <= SUM_W'(rr_r));
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      diff_r[d] <= diff_nxt[d];
      sq_r[d]   <= diff_r[d] * diff_r[d];
    end
    rs_r <= rs_nxt;
    rr_r <= rs_r * rs_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_mem_r  <= 1'b0;
      v_diff_r <= 1'b0;
      v_sq_r   <= 1'b0;
    end else if (cmd.flush || cmd.load) begin
      v_mem_r  <= 1'b0;
      v_diff_r <= 1'b0;
      v_sq_r   <= 1'b0;
    end else begin
      v_mem_r  <= cmd.rd_go || cmd.wall_go;
      v_diff_r <= v_mem_r;
      v_sq_r   <= v_diff_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r       <= 1'b0;
      wall_fail_r <= 1'b0;
      k_r         <= '0;
    end else if (cmd.load) begin
      hit_r       <= 1'b0;
      wall_fail_r <= 1'b0;
      k_r         <= '0;
    end else begin
      if (v_sq_r && cmd.mode_wall && !le) wall_fail_r <= 1'b1;
      if (v_sq_r && !cmd.mode_wall && le) hit_r <= 1'b1;
      if (cmd.rd_go) k_r <= k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        pos_r[d] <= in_pos[d];
      end
      dia_r <= in_diameter;
      bin_r <= bin_nxt;
    end
  end

  assign bin_full = (int'(fill_cur) >= BIN_CAPACITY) || (total_r >= TOTAL_W'(STORE_DEPTH));

  always_comb begin
    if (wall_fail_r) res_status = ST_WALL;
    else if (hit_r) res_status = ST_OVERLAP;
    else if (bin_full) res_status = ST_FULL;
    else res_status = ST_PLACED;
  end

  assign placed = (res_status == ST_PLACED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      for (int b = 0; b < NUM_BINS; b++) begin
        fill_r[b] <= '0;
      end
    end else if (cmd.commit && placed) begin
      total_r       <= total_r + 1'b1;
      fill_r[bin_r] <= fill_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_accepted_r <= placed;
      out_status_r   <= res_status;
      out_bin_r      <= bin_r;
      out_count_r    <= placed ? total_r + 1'b1 : total_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_accepted_r;
  assign out_status       = out_status_r;
  assign out_bin_index    = BIN_W'(out_bin_r);
  assign out_placed_count = out_count_r;

  always_comb begin
    stat             = '0;
    stat.wall_needed = (total_r != '0) && (kc != '0);
    stat.fill_zero   = (fill_cur == '0);
    stat.rd_done     = (k_r == fill_cur);
    stat.pipe_empty  = !(v_mem_r || v_diff_r || v_sq_r);
    stat.hit         = hit_r;
    stat.wall_fail   = wall_fail_r;
    stat.out_busy    = out_valid_r && !out_ready;
  end

endmodule

`default_nettype wire

### sv/binned_overlap_placement_check_top.sv
// Top level of the binned overlap placement check: APB registers, controller, datapath.
// Depends on bopc_pkg, bopc_cfg, bopc_ctrl, bopc_dp.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------------
//   in       | in_valid/in_ready  | in_pos_x, in_pos_y, in_pos_z, in_diameter
//   out      | out_valid/out_ready| out_accepted, out_status, out_bin_index,
//            |                    | out_placed_count
//   cfg      | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
// One item at a time: load, the curved wall test when needed, the bin scan and commit
// run for an item before the next is accepted. The bin scan reads one stored sphere per
// cycle, until a hit or the fill of its bin (up to BIN_CAPACITY), from the single-port
// sphere memory into a three-stage distance pipeline. An empty bin skips the scan.
// The result waits in an output register; the next item is taken meanwhile.
// Reset is synchronous; it empties all bins at once, no clearing pass.
`default_nettype none

module binned_overlap_placement_check_top #(
  parameter int NUM_DIMS     = 3,
  parameter int BIN_CAPACITY = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bopc_pkg::COORD_W-1:0]    in_pos_x,
  input  logic [bopc_pkg::COORD_W-1:0]    in_pos_y,
  input  logic [bopc_pkg::COORD_W-1:0]    in_pos_z,
  input  logic [bopc_pkg::COORD_W-1:0]    in_diameter,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_accepted,
  output logic [bopc_pkg::STATUS_W-1:0]   out_status,
  output logic [bopc_pkg::BIN_W-1:0]      out_bin_index,
  output logic [bopc_pkg::TOTAL_W-1:0]    out_placed_count,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bopc_pkg::APB_AW-1:0]     paddr,
  input  logic [bopc_pkg::APB_DW-1:0]     pwdata,
  output logic [bopc_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);
  import bopc_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  bopc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bopc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bopc_dp #(
    .NUM_DIMS     (NUM_DIMS),
    .BIN_CAPACITY (BIN_CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .stat             (stat),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_diameter      (in_diameter),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_accepted     (out_accepted),
    .out_status       (out_status),
    .out_bin_index    (out_bin_index),
    .out_placed_count (out_placed_count)
  );

endmodule

`default_nettype wire

### sv/bopc_checker.sv
// Port-level checker for binned_overlap_placement_check_top, bound to the top level.
// Depends on bopc_pkg.
`default_nettype none

module bopc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_accepted,
  input logic [bopc_pkg::STATUS_W-1:0] out_status,
  input logic [bopc_pkg::BIN_W-1:0]    out_bin_index,
  input logic [bopc_pkg::TOTAL_W-1:0]  out_placed_count
);
  import bopc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_bin_index) && $stable(out_placed_count))
    else $error("result changed while stalled");

  a_accept_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_accepted == (out_status == ST_PLACED))
    else $error("accepted flag disagrees with status");

  a_reject_needs_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_WALL || out_status == ST_OVERLAP) |->
      out_placed_count != '0)
    else $error("wall or overlap reject with empty store");

  a_placed_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_placed_count != '0)
    else $error("placed item with zero count");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

endmodule

bind binned_overlap_placement_check_top bopc_checker u_bopc_checker (.*);

`default_nettype wire
